// ===== hdl/tls_client_hello_sni_extractor_top_assert.svh =====
// ----------------------------------------------------------------------------
// TLS SNI extractor assertion macros
// Concurrent assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TLS_CLIENT_HELLO_SNI_EXTRACTOR_TOP_ASSERT_SVH
`define TLS_CLIENT_HELLO_SNI_EXTRACTOR_TOP_ASSERT_SVH

// same-cycle implication
`define TSE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tls sni extractor: assertion failed");

// next-cycle implication
`define TSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tls sni extractor: assertion failed");

`endif

// ===== hdl/tlssni_pkg.sv =====
// ----------------------------------------------------------------------------
// TLS SNI extractor package
// Parse phases, protocol constants and result codes.
// ----------------------------------------------------------------------------
package tlssni_pkg;

	typedef enum logic [3:0] {
		PH_HDR       = 4'd0,
		PH_SKIP_VR   = 4'd1,
		PH_SID_LEN   = 4'd2,
		PH_SKIP_SID  = 4'd3,
		PH_CS_LEN    = 4'd4,
		PH_SKIP_CS   = 4'd5,
		PH_COMP_LEN  = 4'd6,
		PH_SKIP_COMP = 4'd7,
		PH_EXTS_LEN  = 4'd8,
		PH_EXT_HDR   = 4'd9,
		PH_SKIP_EXT  = 4'd10,
		PH_SNI_HDR   = 4'd11,
		PH_NAME      = 4'd12,
		PH_DONE      = 4'd13
	} phase_t;

	typedef enum logic {
		KIND_NAME = 1'b0,
		KIND_NONE = 1'b1
	} result_kind_t;

	localparam int unsigned LEN_W   = 13;  // buffer_length and stored end offsets
	localparam int unsigned CMP_W   = 26;  // bound arithmetic, covers 24-bit length + 9
	localparam int unsigned ACC_W   = 24;
	localparam int unsigned SKIP_W  = 16;

	localparam logic [7:0] REC_HANDSHAKE   = 8'h16;
	localparam logic [7:0] TLS_MAJOR       = 8'h03;
	localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
	localparam logic [7:0] SNI_HOST_NAME   = 8'h00;

	localparam int unsigned REC_HDR_LEN  = 5;   // record header bytes
	localparam int unsigned HS_HDR_END   = 9;   // record + handshake header
	localparam int unsigned MIN_SCAN     = 6;
	localparam int unsigned VR_LEN       = 34;  // client version + random
	localparam int unsigned SNI_MIN_BODY = 5;

	function automatic phase_t after_skip(input phase_t ph);
		phase_t nxt;
		case (ph)
			PH_SKIP_VR:   nxt = PH_SID_LEN;
			PH_SKIP_SID:  nxt = PH_CS_LEN;
			PH_SKIP_CS:   nxt = PH_COMP_LEN;
			PH_SKIP_COMP: nxt = PH_EXTS_LEN;
			default:      nxt = PH_EXT_HDR;
		endcase
		return nxt;
	endfunction

endpackage

// ===== hdl/tls_client_hello_sni_extractor_top.sv =====
// ----------------------------------------------------------------------------
// TLS ClientHello SNI extractor
// Walks one buffer byte per transaction; emits the server name or a not-found result.
// ----------------------------------------------------------------------------
// channel | dir | tdata                                   | tuser       | tlast
// s_      | in  | [7:0] data_byte, [20:8] buffer_length    | -           | end_of_buffer
// m_      | out | [7:0] name_byte                         | result_kind | name_last
//
// One byte per cycle while the output is not stalled; a byte passes the input
// register, then the parse step into the output register. The rate is set by the
// per-byte parse state update.
// Reset clears the parse state, both valid flags and the position counter.
// A stalled output holds the input stage; bytes that give no result still
// wait for the output register to be free.
// ----------------------------------------------------------------------------
module tls_client_hello_sni_extractor_top #(
	parameter int unsigned MAX_SCAN = 4096,
	parameter int unsigned NAME_CAP = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] data_byte, [20:8] buffer_length, [23:21] zero
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] name_byte
	output logic        m_tuser,   // [0] result_kind
	output logic        m_tlast
);

	localparam int unsigned PW = $clog2(MAX_SCAN + 1);
	localparam int unsigned NW = $clog2(NAME_CAP);
	localparam int unsigned CW = tlssni_pkg::CMP_W;
	localparam int unsigned LW = tlssni_pkg::LEN_W;
	localparam int unsigned AW = tlssni_pkg::ACC_W;
	localparam int unsigned SW = tlssni_pkg::SKIP_W;

	// input stage
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic [LW-1:0] len_s1;
	logic          eob_s1;

	// parse state
	logic [PW-1:0]      pos_q, pos_d;
	tlssni_pkg::phase_t phase_q, phase_d;
	logic [AW-1:0]      acc_q, acc_d;
	logic [SW-1:0]      skip_q, skip_d;
	logic [LW-1:0]      hs_end_q, hs_end_d;
	logic [LW-1:0]      exts_end_q, exts_end_d;
	logic [LW-1:0]      ext_end_q, ext_end_d;
	logic [NW-1:0]      name_rem_q, name_rem_d;
	logic               emitted_q, emitted_d;

	// output register
	logic                     m_tvalid_q;
	logic [7:0]               m_byte_q;
	tlssni_pkg::result_kind_t m_kind_q;
	logic                     m_last_q;

	logic out_free, proc;
	logic produced, name_end, res_valid;

	logic [CW-1:0] scan, p_c, p1, p2, p4, v_c, sum_c, len_c;
	logic [15:0]   v16;
	logic [SW-1:0] skip_dec;
	logic [NW-1:0] name_dec;

	assign out_free = !m_tvalid_q || m_tready;
	assign proc     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata[7:0];
			len_s1  <= s_tdata[20:8];
			eob_s1  <= s_tlast;
		end
	end

	always_comb begin
		len_c    = CW'(len_s1);
		scan     = (len_c > CW'(MAX_SCAN)) ? CW'(MAX_SCAN) : len_c;
		p_c      = CW'(pos_q);
		p1       = p_c + CW'(1);
		p2       = p_c + CW'(2);
		p4       = p_c + CW'(4);
		v16      = {acc_q[7:0], byte_s1};
		v_c      = CW'(v16);
		sum_c    = p1 + v_c;
		skip_dec = skip_q - SW'(1);
		name_dec = name_rem_q - NW'(1);
	end

	always_comb begin
		pos_d      = pos_q;
		phase_d    = phase_q;
		acc_d      = acc_q;
		skip_d     = skip_q;
		hs_end_d   = hs_end_q;
		exts_end_d = exts_end_q;
		ext_end_d  = ext_end_q;
		name_rem_d = name_rem_q;
		emitted_d  = emitted_q;
		produced   = 1'b0;
		name_end   = 1'b0;

		if (p_c < scan) begin
			case (phase_q)
				tlssni_pkg::PH_HDR: begin
					if (p_c == CW'(0)) begin
						if (scan < CW'(tlssni_pkg::MIN_SCAN) ||
						    byte_s1 != tlssni_pkg::REC_HANDSHAKE)
							phase_d = tlssni_pkg::PH_DONE;
					end else if (p_c == CW'(1)) begin
						if (byte_s1 != tlssni_pkg::TLS_MAJOR)
							phase_d = tlssni_pkg::PH_DONE;
					end else if (p_c == CW'(3)) begin
						acc_d = AW'(byte_s1);
					end else if (p_c == CW'(4)) begin
						if (v_c + CW'(tlssni_pkg::REC_HDR_LEN) > scan)
							phase_d = tlssni_pkg::PH_DONE;
					end else if (p_c == CW'(5)) begin
						if (byte_s1 != tlssni_pkg::HS_CLIENT_HELLO ||
						    scan < CW'(tlssni_pkg::HS_HDR_END))
							phase_d = tlssni_pkg::PH_DONE;
						acc_d = '0;
					end else if (p_c == CW'(6) || p_c == CW'(7)) begin
						acc_d = {acc_q[15:0], byte_s1};
					end else if (p_c == CW'(8)) begin
						if (CW'({acc_q[15:0], byte_s1}) + CW'(tlssni_pkg::HS_HDR_END) > scan) begin
							phase_d = tlssni_pkg::PH_DONE;
						end else begin
							hs_end_d = LW'(CW'({acc_q[15:0], byte_s1}) +
							               CW'(tlssni_pkg::HS_HDR_END));
							phase_d  = tlssni_pkg::PH_SKIP_VR;
							skip_d   = SW'(tlssni_pkg::VR_LEN);
						end
					end
				end
				tlssni_pkg::PH_SKIP_VR, tlssni_pkg::PH_SKIP_SID, tlssni_pkg::PH_SKIP_CS,
				tlssni_pkg::PH_SKIP_COMP, tlssni_pkg::PH_SKIP_EXT: begin
					skip_d = skip_dec;
					if (skip_dec == '0) begin
						phase_d = tlssni_pkg::after_skip(phase_q);
						acc_d   = '0;
					end
				end
				tlssni_pkg::PH_SID_LEN, tlssni_pkg::PH_COMP_LEN: begin
					if (p1 > CW'(hs_end_q)) begin
						phase_d = tlssni_pkg::PH_DONE;
					end else if (byte_s1 == 8'd0) begin
						phase_d = (phase_q == tlssni_pkg::PH_SID_LEN) ?
						          tlssni_pkg::PH_CS_LEN : tlssni_pkg::PH_EXTS_LEN;
						skip_d  = '0;
						acc_d   = '0;
					end else begin
						phase_d = (phase_q == tlssni_pkg::PH_SID_LEN) ?
						          tlssni_pkg::PH_SKIP_SID : tlssni_pkg::PH_SKIP_COMP;
						skip_d  = SW'(byte_s1);
					end
				end
				tlssni_pkg::PH_CS_LEN, tlssni_pkg::PH_EXTS_LEN: begin
					if (skip_q == '0) begin
						if (p2 > CW'(hs_end_q))
							phase_d = tlssni_pkg::PH_DONE;
						acc_d  = AW'(byte_s1);
						skip_d = SW'(1);
					end else if (phase_q == tlssni_pkg::PH_CS_LEN) begin
						if (v16 == 16'd0) begin
							phase_d = tlssni_pkg::PH_COMP_LEN;
							skip_d  = '0;
							acc_d   = '0;
						end else begin
							phase_d = tlssni_pkg::PH_SKIP_CS;
							skip_d  = SW'(v16);
						end
					end else if (sum_c > CW'(hs_end_q)) begin
						phase_d = tlssni_pkg::PH_DONE;
					end else begin
						exts_end_d = LW'(sum_c);
						phase_d    = tlssni_pkg::PH_EXT_HDR;
						skip_d     = '0;
						acc_d      = '0;
					end
				end
				tlssni_pkg::PH_EXT_HDR: begin
					if (skip_q == SW'(0)) begin
						if (p4 > CW'(exts_end_q)) begin
							phase_d = tlssni_pkg::PH_DONE;
						end else begin
							acc_d  = AW'(byte_s1);
							skip_d = skip_q + SW'(1);
						end
					end else if (skip_q == SW'(1)) begin
						acc_d  = AW'({acc_q[7:0], byte_s1});
						skip_d = skip_q + SW'(1);
					end else if (skip_q == SW'(2)) begin
						// bit 16 flags a nonzero extension type
						acc_d  = {7'd0, (acc_q != '0), 8'd0, byte_s1};
						skip_d = skip_q + SW'(1);
					end else begin
						if (sum_c > CW'(exts_end_q)) begin
							phase_d = tlssni_pkg::PH_DONE;
						end else if (!acc_q[16] && v16 >= 16'(tlssni_pkg::SNI_MIN_BODY)) begin
							ext_end_d = LW'(sum_c);
							phase_d   = tlssni_pkg::PH_SNI_HDR;
							skip_d    = '0;
							acc_d     = '0;
						end else if (v16 == 16'd0) begin
							phase_d = tlssni_pkg::PH_EXT_HDR;
							skip_d  = '0;
							acc_d   = '0;
						end else begin
							phase_d = tlssni_pkg::PH_SKIP_EXT;
							skip_d  = SW'(v16);
						end
					end
				end
				tlssni_pkg::PH_SNI_HDR: begin
					if (skip_q == SW'(2) && byte_s1 != tlssni_pkg::SNI_HOST_NAME) begin
						phase_d = tlssni_pkg::PH_DONE;
					end else if (skip_q == SW'(4)) begin
						if (sum_c > CW'(ext_end_q) || v16 == 16'd0 ||
						    v_c >= CW'(NAME_CAP)) begin
							phase_d = tlssni_pkg::PH_DONE;
						end else begin
							name_rem_d = NW'(v16);
							phase_d    = tlssni_pkg::PH_NAME;
						end
					end else begin
						if (skip_q == SW'(3))
							acc_d = AW'(byte_s1);
						skip_d = skip_q + SW'(1);
					end
				end
				tlssni_pkg::PH_NAME: begin
					name_rem_d = name_dec;
					emitted_d  = 1'b1;
					produced   = 1'b1;
					name_end   = (name_dec == '0);
					if (name_dec == '0)
						phase_d = tlssni_pkg::PH_DONE;
				end
				default: begin
				end
			endcase
		end

		if (pos_q < PW'(MAX_SCAN))
			pos_d = pos_q + PW'(1);

		res_valid = produced || (eob_s1 && !emitted_q);

		// end of buffer returns the parse state to its reset values
		if (eob_s1) begin
			pos_d      = '0;
			phase_d    = tlssni_pkg::PH_HDR;
			acc_d      = '0;
			skip_d     = '0;
			hs_end_d   = '0;
			exts_end_d = '0;
			ext_end_d  = '0;
			name_rem_d = '0;
			emitted_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			phase_q    <= tlssni_pkg::PH_HDR;
			acc_q      <= '0;
			skip_q     <= '0;
			hs_end_q   <= '0;
			exts_end_q <= '0;
			ext_end_q  <= '0;
			name_rem_q <= '0;
			emitted_q  <= 1'b0;
		end else if (proc) begin
			pos_q      <= pos_d;
			phase_q    <= phase_d;
			acc_q      <= acc_d;
			skip_q     <= skip_d;
			hs_end_q   <= hs_end_d;
			exts_end_q <= exts_end_d;
			ext_end_q  <= ext_end_d;
			name_rem_q <= name_rem_d;
			emitted_q  <= emitted_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= proc && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && res_valid) begin
			m_kind_q <= produced ? tlssni_pkg::KIND_NAME : tlssni_pkg::KIND_NONE;
			m_byte_q <= produced ? byte_s1 : 8'd0;
			m_last_q <= produced && (name_end || eob_s1);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_byte_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;

endmodule

// ===== hdl/tlssni_checker.sv =====
// ----------------------------------------------------------------------------
// TLS SNI extractor port checker
// Watches the top-level ports and flags behavior the block must never show.
// ----------------------------------------------------------------------------
`include "tls_client_hello_sni_extractor_top_assert.svh"

module tlssni_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,   // [7:0] data_byte, [20:8] buffer_length, [23:21] zero
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,   // [7:0] name_byte
	input logic        m_tuser,   // [0] result_kind
	input logic        m_tlast
);

	// a stalled result transaction keeps its payload
	`TSE_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

	// a waiting input transaction keeps its payload
	`TSE_ASSERT_NEXT(a_in_hold, clk, arst_n, s_tvalid && !s_tready,
		s_tvalid && $stable(s_tdata) && $stable(s_tlast))

	// a not-found result carries no name byte and no last mark
	`TSE_ASSERT_IMPLY(a_none_payload, clk, arst_n,
		m_tvalid && (m_tuser == tlssni_pkg::KIND_NONE), (m_tdata == 8'd0) && !m_tlast)

	// with the output register empty, the input side never stalls
	`TSE_ASSERT_IMPLY(a_empty_ready, clk, arst_n, !m_tvalid, s_tready)

endmodule

bind tls_client_hello_sni_extractor_top tlssni_checker u_tlssni_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
